>>> src/tht_pkg.sv
// shared constants, types and helper functions of the typed handle table
`default_nettype none

package tht_pkg;

  localparam int TableDepth = 1024;
  localparam int HandleW    = 10;
  localparam int ObjW       = 32;
  localparam int KindW      = 8;
  localparam int ColW       = 5;
  localparam int RowSlots   = 2 ** ColW;
  localparam int RowCount   = TableDepth / RowSlots;
  localparam int RowW       = $clog2(RowCount);

  typedef enum logic [1:0] {
    REQ_CREATE = 2'd0,
    REQ_CLOSE  = 2'd1,
    REQ_LOOKUP = 2'd2,
    REQ_SCAN   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_NO_RESOURCES = 2'd1,
    ST_BAD_HANDLE   = 2'd2,
    ST_NO_MORE      = 2'd3
  } status_e;

  // one row of the slot table: valid marks and kinds of RowSlots slots
  typedef struct packed {
    logic [RowSlots-1:0]            valid;
    logic [RowSlots-1:0][KindW-1:0] kind;
  } row_t;

  typedef struct packed {
    logic                row_re;
    logic                row_we;
    logic [RowW-1:0]     row_raddr;
    logic [RowW-1:0]     row_waddr;
    row_t                row_wdata;
    logic                obj_re;
    logic                obj_we;
    logic [HandleW-1:0]  obj_raddr;
    logic [HandleW-1:0]  obj_waddr;
    logic [ObjW-1:0]     obj_wdata;
  } mem_cmd_t;

  typedef struct packed {
    status_e             status;
    logic [HandleW-1:0]  handle;
    logic [ObjW-1:0]     object;
  } result_t;

  // lowest set bit of a row mask
  function automatic logic [ColW-1:0] lowest_col(input logic [RowSlots-1:0] vec);
    logic [ColW-1:0] pos;
    pos = '0;
    for (int i = RowSlots - 1; i >= 0; i--) begin
      if (vec[i]) pos = ColW'(i);
    end
    return pos;
  endfunction

  // lowest set bit of a per-row summary mask
  function automatic logic [RowW-1:0] lowest_row(input logic [RowCount-1:0] vec);
    logic [RowW-1:0] pos;
    pos = '0;
    for (int i = RowCount - 1; i >= 0; i--) begin
      if (vec[i]) pos = RowW'(i);
    end
    return pos;
  endfunction

endpackage

`default_nettype wire

>>> src/typed_handle_table.sv
// top level of the typed handle table: sequencer, slot memories and output register
// create, close and lookup read the slot row memory before the result is ready; a create
//   on a full table, a bad scan start or a scan from the last handle skip the reads; a
//   type scan reads up to 32 rows of 32 slots; the row memory read port sets that pace
// a new item is taken only in idle, once the last result has moved to the output register
// reset: control state clears at once, then a clearing pass empties every row
`default_nettype none

module typed_handle_table import tht_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         req_type_i,
  input  logic [HandleW-1:0] slot_index_i,
  input  logic               scan_from_start_i,
  input  logic [ObjW-1:0]    object_id_i,
  input  logic [KindW-1:0]   object_kind_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic [HandleW-1:0] handle_out_o,
  output logic [ObjW-1:0]    object_out_o
);

  // memory command and read data between sequencer and storage
  mem_cmd_t        mem_cmd;
  row_t            row_rdata;
  logic [ObjW-1:0] obj_rdata;

  // finished result waiting for the output register
  logic    res_valid;
  result_t res;
  logic    res_take;

  // output register, lets the next item start while a result waits
  logic               out_valid_q, out_valid_d;
  logic [1:0]         status_q;
  logic [HandleW-1:0] handle_q;
  logic [ObjW-1:0]    object_q;

  tht_ctrl u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .req_type_i        (req_type_i),
    .slot_index_i      (slot_index_i),
    .scan_from_start_i (scan_from_start_i),
    .object_id_i       (object_id_i),
    .object_kind_i     (object_kind_i),
    .row_rdata_i       (row_rdata),
    .obj_rdata_i       (obj_rdata),
    .mem_cmd_o         (mem_cmd),
    .res_valid_o       (res_valid),
    .res_o             (res),
    .res_take_i        (res_take)
  );

  // row memory holds valid marks and kinds, 32 slots per row; object ids apart
  tht_store u_store (
    .clk_i       (clk_i),
    .cmd_i       (mem_cmd),
    .row_rdata_o (row_rdata),
    .obj_rdata_o (obj_rdata)
  );

  // the result moves on when the output register is empty or being drained
  assign res_take = res_valid && (!out_valid_q || out_ready_i);

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_take) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // payload only loads with a new result, so it holds while stalled
  always_ff @(posedge clk_i) begin
    if (res_take) begin
      status_q <= res.status;
      handle_q <= res.handle;
      object_q <= res.object;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign handle_out_o = handle_q;
  assign object_out_o = object_q;

endmodule

`default_nettype wire

>>> src/tht_store.sv
// slot row memory and object id memory, both with registered reads
`default_nettype none

module tht_store import tht_pkg::*; (
  input  logic            clk_i,
  input  mem_cmd_t        cmd_i,
  output row_t            row_rdata_o,
  output logic [ObjW-1:0] obj_rdata_o
);

  row_t            row_mem [RowCount];
  logic [ObjW-1:0] obj_mem [TableDepth];

  row_t            row_rdata_q;
  logic [ObjW-1:0] obj_rdata_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.row_we) begin
      row_mem[cmd_i.row_waddr] <= cmd_i.row_wdata;
    end
    if (cmd_i.row_re) begin
      row_rdata_q <= row_mem[cmd_i.row_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.obj_we) begin
      obj_mem[cmd_i.obj_waddr] <= cmd_i.obj_wdata;
    end
    if (cmd_i.obj_re) begin
      obj_rdata_q <= obj_mem[cmd_i.obj_raddr];
    end
  end

  assign row_rdata_o = row_rdata_q;
  assign obj_rdata_o = obj_rdata_q;

endmodule

`default_nettype wire

>>> src/tht_ctrl.sv
// request sequencer: clear pass, read-modify-write of slot rows, row-by-row scan
`default_nettype none

module tht_ctrl import tht_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         req_type_i,
  input  logic [HandleW-1:0] slot_index_i,
  input  logic               scan_from_start_i,
  input  logic [ObjW-1:0]    object_id_i,
  input  logic [KindW-1:0]   object_kind_i,
  input  row_t               row_rdata_i,
  input  logic [ObjW-1:0]    obj_rdata_i,
  output mem_cmd_t           mem_cmd_o,
  output logic               res_valid_o,
  output result_t            res_o,
  input  logic               res_take_i
);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_EVAL  = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

  localparam logic [HandleW:0] DepthExt = (HandleW + 1)'(TableDepth);

  state_e              state_q, state_d;
  logic [RowW-1:0]     clr_q, clr_d;
  logic [RowCount-1:0] full_q, full_d;
  req_e                req_q, req_d;
  logic [HandleW-1:0]  idx_q, idx_d;
  logic [KindW-1:0]    kind_q, kind_d;
  logic [ObjW-1:0]     obj_q, obj_d;
  logic [RowW-1:0]     row_q, row_d;
  logic [ColW-1:0]     col_q, col_d;
  logic                first_q, first_d;
  result_t             res_q, res_d;

  logic [RowSlots-1:0] slot0_mask;
  logic [RowSlots-1:0] free_bits;
  logic [ColW-1:0]     free_col;
  logic                any_row_free;
  logic [RowW-1:0]     free_row;
  logic [RowSlots-1:0] hits;
  logic                usable;
  logic [HandleW:0]    scan_start;
  logic                scan_bad;
  logic                scan_past;
  row_t                row_wr;
  mem_cmd_t            cmd;

  // slot zero is never handed out
  assign slot0_mask   = (row_q == '0) ? RowSlots'(1) : '0;
  assign free_bits    = ~row_rdata_i.valid & ~slot0_mask;
  assign free_col     = lowest_col(free_bits);
  assign any_row_free = |(~full_q);
  assign free_row     = lowest_row(~full_q);
  assign usable       = (idx_q != '0) && ({1'b0, idx_q} < DepthExt);

  assign scan_start = scan_from_start_i ? '0 : ({1'b0, slot_index_i} + (HandleW + 1)'(1));
  assign scan_bad   = !scan_from_start_i && ({1'b0, slot_index_i} >= DepthExt);
  assign scan_past  = scan_start >= DepthExt;

  always_comb begin
    for (int c = 0; c < RowSlots; c++) begin
      hits[c] = row_rdata_i.valid[c] && (row_rdata_i.kind[c] == kind_q) &&
                (!first_q || (ColW'(c) >= col_q));
    end
  end

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    full_d     = full_q;
    req_d      = req_q;
    idx_d      = idx_q;
    kind_d     = kind_q;
    obj_d      = obj_q;
    row_d      = row_q;
    col_d      = col_q;
    first_d    = first_q;
    res_d      = res_q;
    row_wr     = row_rdata_i;
    cmd        = '0;
    in_ready_o = 1'b0;
    res_valid_o = 1'b0;

    case (state_q)
      S_CLEAR: begin
        cmd.row_we    = 1'b1;
        cmd.row_waddr = clr_q;
        cmd.row_wdata = '0;
        if (clr_q == RowW'(RowCount - 1)) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end

      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          req_d   = req_e'(req_type_i);
          idx_d   = slot_index_i;
          kind_d  = object_kind_i;
          obj_d   = object_id_i;
          first_d = 1'b1;
          res_d.status = ST_OK;
          res_d.handle = '0;
          res_d.object = '0;
          case (req_e'(req_type_i))
            REQ_CREATE: begin
              if (any_row_free) begin
                row_d         = free_row;
                cmd.row_re    = 1'b1;
                cmd.row_raddr = free_row;
                state_d       = S_EVAL;
              end else begin
                res_d.status = ST_NO_RESOURCES;
                state_d      = S_DONE;
              end
            end
            REQ_CLOSE, REQ_LOOKUP: begin
              row_d         = slot_index_i[ColW+RowW-1:ColW];
              col_d         = slot_index_i[ColW-1:0];
              cmd.row_re    = 1'b1;
              cmd.row_raddr = slot_index_i[ColW+RowW-1:ColW];
              cmd.obj_re    = 1'b1;
              cmd.obj_raddr = slot_index_i;
              state_d       = S_EVAL;
            end
            REQ_SCAN: begin
              if (scan_bad) begin
                res_d.status = ST_BAD_HANDLE;
                state_d      = S_DONE;
              end else if (scan_past) begin
                res_d.status = ST_NO_MORE;
                state_d      = S_DONE;
              end else begin
                row_d         = scan_start[ColW+RowW-1:ColW];
                col_d         = scan_start[ColW-1:0];
                cmd.row_re    = 1'b1;
                cmd.row_raddr = scan_start[ColW+RowW-1:ColW];
                state_d       = S_EVAL;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      S_EVAL: begin
        case (req_q)
          REQ_CREATE: begin
            row_wr.valid[free_col] = 1'b1;
            row_wr.kind[free_col]  = kind_q;
            cmd.row_we     = 1'b1;
            cmd.row_waddr  = row_q;
            cmd.row_wdata  = row_wr;
            cmd.obj_we     = 1'b1;
            cmd.obj_waddr  = {row_q, free_col};
            cmd.obj_wdata  = obj_q;
            full_d[row_q]  = &(row_wr.valid | slot0_mask);
            res_d.handle   = {row_q, free_col};
            state_d        = S_DONE;
          end
          REQ_CLOSE: begin
            if (usable && row_rdata_i.valid[col_q]) begin
              row_wr.valid[col_q] = 1'b0;
              cmd.row_we    = 1'b1;
              cmd.row_waddr = row_q;
              cmd.row_wdata = row_wr;
              full_d[row_q] = 1'b0;
              res_d.object  = obj_rdata_i;
            end else begin
              res_d.status = ST_BAD_HANDLE;
            end
            state_d = S_DONE;
          end
          REQ_LOOKUP: begin
            if (usable && row_rdata_i.valid[col_q] &&
                (row_rdata_i.kind[col_q] == kind_q)) begin
              res_d.object = obj_rdata_i;
            end else begin
              res_d.status = ST_BAD_HANDLE;
            end
            state_d = S_DONE;
          end
          REQ_SCAN: begin
            if (|hits) begin
              res_d.handle = {row_q, lowest_col(hits)};
              state_d      = S_DONE;
            end else if (row_q == RowW'(RowCount - 1)) begin
              res_d.status = ST_NO_MORE;
              state_d      = S_DONE;
            end else begin
              row_d         = row_q + 1'b1;
              first_d       = 1'b0;
              cmd.row_re    = 1'b1;
              cmd.row_raddr = row_q + 1'b1;
            end
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end

      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      full_q  <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      full_q  <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    idx_q   <= idx_d;
    kind_q  <= kind_d;
    obj_q   <= obj_d;
    row_q   <= row_d;
    col_q   <= col_d;
    first_q <= first_d;
    res_q   <= res_d;
  end

  assign mem_cmd_o = cmd;
  assign res_o     = res_q;

endmodule

`default_nettype wire

>>> src/tht_checker.sv
// port-level checks of the typed handle table, bound to the top level
`default_nettype none

module tht_checker import tht_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [1:0]         status_o,
  input logic [HandleW-1:0] handle_out_o,
  input logic [ObjW-1:0]    object_out_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(status_o) && $stable(handle_out_o) && $stable(object_out_o))
    else $error("stalled result changed");

  // failures carry no handle and no object
  a_fail_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> (handle_out_o == '0) && (object_out_o == '0))
    else $error("failed result carries data");

  // a good result carries a handle or an object, never both
  a_ok_one_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_OK) |-> (handle_out_o == '0) || (object_out_o == '0))
    else $error("good result carries handle and object");

  // no item is taken in the first cycle after reset, the clearing pass runs first
  a_clear_first: assert property (@(posedge clk_i)
    !rst_ni |=> !in_ready_o)
    else $error("item taken during clearing pass");

endmodule

bind typed_handle_table tht_checker u_tht_checker (.*);

`default_nettype wire
